[rtl/tmp_pkg.sv]
package tmp_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned TsW      = 16;
  localparam int unsigned LimW     = 31;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned MacAW    = 32;
  localparam int unsigned MacBW    = 16;
  localparam int unsigned AccW     = 64;
  localparam int unsigned RootW    = 32;
  localparam int unsigned SqrtSteps = 32;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgTimeStep  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgVelLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAccLimit  = 2'd2;

  localparam logic [TsW-1:0]  TimeStepRst = 16'd655;
  localparam logic [LimW-1:0] VelLimitRst = 31'd7864;
  localparam logic [LimW-1:0] AccLimitRst = 31'd26214;

  // 1e-4 in Q16.16 is 6.5536 raw: an error magnitude below 7 snaps
  localparam logic [DataW:0] SnapLimit = 33'd7;

  typedef struct packed {
    logic             en;
    logic             clear;
    logic [MacAW-1:0] a;
    logic [MacBW-1:0] b;
  } mac_req_t;

  typedef struct packed {
    logic           start;
    logic [AccW-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [RootW-1:0] root;
  } sqrt_rsp_t;

endpackage

[rtl/tmp_if.sv]
interface tmp_cmd_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [31:0] target_position;
  logic [31:0] load_position;

  modport source (output valid, command, target_position, load_position, input ready);
  modport sink   (input valid, command, target_position, load_position, output ready);
endinterface

interface tmp_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  logic [31:0] velocity;
  logic        arrived;

  modport source (output valid, position, velocity, arrived, input ready);
  modport sink   (input valid, position, velocity, arrived, output ready);
endinterface

interface tmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/tmp_mac.sv]
// Shared multiply-accumulate: acc = (clear ? 0 : acc << 16) + a * b.
module tmp_mac (
  input  logic                        clk_i,
  input  tmp_pkg::mac_req_t           req_i,
  output logic [tmp_pkg::AccW-1:0]    acc_o
);

  localparam int unsigned ProdW = tmp_pkg::MacAW + tmp_pkg::MacBW;

  logic [ProdW-1:0]         prod;
  logic [tmp_pkg::AccW-1:0] base;
  logic [tmp_pkg::AccW-1:0] acc_d;
  logic [tmp_pkg::AccW-1:0] acc_q;

  assign prod  = req_i.a * req_i.b;
  assign base  = req_i.clear ? '0 : (acc_q << tmp_pkg::MacBW);
  assign acc_d = base + {{(tmp_pkg::AccW-ProdW){1'b0}}, prod};

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

[rtl/tmp_sqrt.sv]
// Digit-by-digit integer square root, two radicand bits per cycle.
module tmp_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tmp_pkg::sqrt_req_t  req_i,
  output tmp_pkg::sqrt_rsp_t  rsp_o
);

  localparam int unsigned RemW = tmp_pkg::RootW + 2;
  localparam int unsigned CntW = $clog2(tmp_pkg::SqrtSteps);

  logic [tmp_pkg::AccW-1:0]  rad_q;
  logic [RemW-1:0]           rem_q;
  logic [tmp_pkg::RootW-1:0] root_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [RemW+1:0]           cat;
  logic [RemW+1:0]           trial;
  logic                      take;

  assign cat   = {rem_q, rad_q[tmp_pkg::AccW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};
  assign take  = cat >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(tmp_pkg::SqrtSteps - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rad_q  <= req_i.radicand;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (take) begin
        rem_q  <= RemW'(cat - trial);
        root_q <= {root_q[tmp_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= RemW'(cat);
        root_q <= {root_q[tmp_pkg::RootW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

[rtl/trapezoidal_motion_profile.sv]
// Channel  | Dir | Payload                                       | Transfer
// cmd_i    | in  | command, target_position, load_position       | valid & ready
// res_o    | out | position, velocity, arrived                   | valid & ready
// cfg_i    | in  | reg_index, wdata (time_step, vel/accel limit) | valid & ready
//
// Load commands and steps with a zero time step pass from accept to S_FIN and then into the output register.
// A regular step is dominated by the 32-iteration square root; one shared 32x16
// multiply-accumulate serves the three products around it.
// One transaction is in flight at a time; cmd_i is ready only when the sequencer idles.
// Results sit in an output register, so a stalled res_o holds only the final write.
// Reset clears position and velocity and loads the register defaults; cfg_i is always ready.
module trapezoidal_motion_profile (
  input  logic          clk_i,
  input  logic          rst_ni,
  tmp_cmd_if.sink       cmd_i,
  tmp_res_if.source     res_o,
  tmp_cfg_if.sink       cfg_i
);

  localparam int unsigned StW = 4;
  localparam logic [StW-1:0] S_IDLE = 4'd0;
  localparam logic [StW-1:0] S_ERR  = 4'd1;
  localparam logic [StW-1:0] S_MAG0 = 4'd2;
  localparam logic [StW-1:0] S_MAG1 = 4'd3;
  localparam logic [StW-1:0] S_MAG2 = 4'd4;
  localparam logic [StW-1:0] S_SQST = 4'd5;
  localparam logic [StW-1:0] S_SQWT = 4'd6;
  localparam logic [StW-1:0] S_DV   = 4'd7;
  localparam logic [StW-1:0] S_VUPD = 4'd8;
  localparam logic [StW-1:0] S_PMUL = 4'd9;
  localparam logic [StW-1:0] S_POS  = 4'd10;
  localparam logic [StW-1:0] S_FIN  = 4'd11;

  localparam int unsigned W  = tmp_pkg::DataW;
  localparam int unsigned WX = W + 2;          // room for differences of 33-bit values

  logic [StW-1:0] state_q, state_d;

  // configuration
  logic [tmp_pkg::TsW-1:0]  ts_q;
  logic [tmp_pkg::LimW-1:0] vlim_q;
  logic [tmp_pkg::LimW-1:0] accel_q;

  // kept state and per-step scratch
  logic signed [W-1:0]  pos_q, pos_d;
  logic signed [W-1:0]  vel_q, vel_d;
  logic                 arr_q, arr_d;
  logic signed [W-1:0]  tgt_q, tgt_d;
  logic [W:0]           mag_q, mag_d;
  logic                 up_q, up_d;
  logic signed [WX-1:0] dv_q, dv_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic [W-1:0]         out_pos_q, out_vel_q;
  logic                 out_arr_q;
  logic                 out_load;

  tmp_pkg::mac_req_t         mac_req;
  logic [tmp_pkg::AccW-1:0]  acc;
  tmp_pkg::sqrt_req_t        sq_req;
  tmp_pkg::sqrt_rsp_t        sq_rsp;

  // datapath intermediates
  logic signed [W:0]    err;
  logic [W:0]           err_mag;
  logic [W-1:0]         speed;
  logic signed [WX-1:0] desired;
  logic signed [WX-1:0] dvmax;
  logic signed [WX-1:0] dv_clamp;
  logic signed [WX-1:0] vel_sum;
  logic [W-1:0]         vel_mag;
  logic signed [WX-1:0] delta;
  logic signed [WX-1:0] np_wide;
  logic signed [W-1:0]  np;
  logic                 overshoot;

  tmp_mac u_mac (
    .clk_i (clk_i),
    .req_i (mac_req),
    .acc_o (acc)
  );

  tmp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  // Configuration writes land at once; an unused index is dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= tmp_pkg::TimeStepRst;
      vlim_q  <= tmp_pkg::VelLimitRst;
      accel_q <= tmp_pkg::AccLimitRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        tmp_pkg::CfgTimeStep: ts_q    <= cfg_i.wdata[tmp_pkg::TsW-1:0];
        tmp_pkg::CfgVelLimit: vlim_q  <= cfg_i.wdata[tmp_pkg::LimW-1:0];
        tmp_pkg::CfgAccLimit: accel_q <= cfg_i.wdata[tmp_pkg::LimW-1:0];
        default: ;
      endcase
    end
  end

  assign cmd_i.ready = (state_q == S_IDLE);

  // Error against the target, exact in 33 bits.
  assign err     = $signed({tgt_q[W-1], tgt_q}) - $signed({pos_q[W-1], pos_q});
  assign err_mag = err[W] ? (W+1)'(-err) : err;

  // Desired speed: lesser of the stopping speed and the limit, signed toward the target.
  assign speed   = (sq_rsp.root < {1'b0, vlim_q}) ? sq_rsp.root : {1'b0, vlim_q};
  assign desired = up_q ? $signed({2'b00, speed}) : -$signed({2'b00, speed});

  // Velocity step bound, from accel * dt left in the accumulator during the root.
  assign dvmax = $signed({3'b000, acc[tmp_pkg::MacBW +: tmp_pkg::LimW]});

  always_comb begin
    if (dv_q > dvmax) begin
      dv_clamp = dvmax;
    end else if (dv_q < -dvmax) begin
      dv_clamp = -dvmax;
    end else begin
      dv_clamp = dv_q;
    end
  end

  assign vel_sum = $signed({{2{vel_q[W-1]}}, vel_q}) + dv_clamp;
  assign vel_mag = vel_q[W-1] ? W'(-vel_q) : vel_q;

  // Position increment: |v| * dt >> 16 with the sign of v, then saturate.
  assign delta   = vel_q[W-1]
                   ? -$signed({3'b000, acc[tmp_pkg::MacBW +: tmp_pkg::LimW]})
                   :  $signed({3'b000, acc[tmp_pkg::MacBW +: tmp_pkg::LimW]});
  assign np_wide = $signed({{2{pos_q[W-1]}}, pos_q}) + delta;

  always_comb begin
    if (np_wide[WX-1:W-1] == '0 || np_wide[WX-1:W-1] == '1) begin
      np = np_wide[W-1:0];
    end else if (np_wide[WX-1]) begin
      np = {1'b1, {(W-1){1'b0}}};
    end else begin
      np = {1'b0, {(W-1){1'b1}}};
    end
  end

  assign overshoot = up_q ? (np >= tgt_q) : (np <= tgt_q);

  assign out_load = (state_q == S_FIN) && (!out_valid_q || res_o.ready);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    vel_d   = vel_q;
    arr_d   = arr_q;
    tgt_d   = tgt_q;
    mag_d   = mag_q;
    up_d    = up_q;
    dv_d    = dv_q;
    mac_req = '0;
    sq_req  = '0;
    sq_req.radicand = {acc[tmp_pkg::AccW-2:0], 1'b0};

    case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          arr_d = 1'b0;
          if (cmd_i.command) begin
            pos_d   = cmd_i.load_position;
            vel_d   = '0;
            state_d = S_FIN;
          end else if (ts_q == '0) begin
            state_d = S_FIN;
          end else begin
            tgt_d   = cmd_i.target_position;
            state_d = S_ERR;
          end
        end
      end
      S_ERR: begin
        if (err_mag < tmp_pkg::SnapLimit) begin
          pos_d   = tgt_q;
          vel_d   = '0;
          arr_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          mag_d   = err_mag;
          up_d    = !err[W];
          state_d = S_MAG0;
        end
      end
      // accel * |error|, top bit first, then 16 bits of the magnitude per pass
      S_MAG0: begin
        mac_req.en    = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.a     = {1'b0, accel_q};
        mac_req.b     = {{(tmp_pkg::MacBW-1){1'b0}}, mag_q[W]};
        state_d       = S_MAG1;
      end
      S_MAG1: begin
        mac_req.en = 1'b1;
        mac_req.a  = {1'b0, accel_q};
        mac_req.b  = mag_q[W-1 -: tmp_pkg::MacBW];
        state_d    = S_MAG2;
      end
      S_MAG2: begin
        mac_req.en = 1'b1;
        mac_req.a  = {1'b0, accel_q};
        mac_req.b  = mag_q[tmp_pkg::MacBW-1:0];
        state_d    = S_SQST;
      end
      // launch the root on 2*accel*|error|, reuse the multiplier for accel*dt
      S_SQST: begin
        sq_req.start  = 1'b1;
        mac_req.en    = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.a     = {1'b0, accel_q};
        mac_req.b     = ts_q;
        state_d       = S_SQWT;
      end
      S_SQWT: begin
        if (sq_rsp.done) begin
          state_d = S_DV;
        end
      end
      S_DV: begin
        dv_d    = desired - $signed({{2{vel_q[W-1]}}, vel_q});
        state_d = S_VUPD;
      end
      S_VUPD: begin
        vel_d   = vel_sum[W-1:0];
        state_d = S_PMUL;
      end
      S_PMUL: begin
        mac_req.en    = 1'b1;
        mac_req.clear = 1'b1;
        mac_req.a     = vel_mag;
        mac_req.b     = ts_q;
        state_d       = S_POS;
      end
      S_POS: begin
        if (overshoot) begin
          pos_d = tgt_q;
          vel_d = '0;
          arr_d = 1'b1;
        end else begin
          pos_d = np;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      arr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      arr_q       <= arr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_q <= tgt_d;
    mag_q <= mag_d;
    up_q  <= up_d;
    dv_q  <= dv_d;
    if (out_load) begin
      out_pos_q <= pos_q;
      out_vel_q <= vel_q;
      out_arr_q <= arr_q;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.position = out_pos_q;
  assign res_o.velocity = out_vel_q;
  assign res_o.arrived  = out_arr_q;

`ifndef SYNTHESIS
  // a load transaction goes straight to the result with zero velocity
  a_load_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.valid && cmd_i.ready && cmd_i.command |=>
      state_q == S_FIN && pos_q == $past(cmd_i.load_position) && vel_q == '0)
    else $error("load transaction did not set position and clear velocity");

  // a snap onto the target always reports zero velocity
  a_arrived_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.arrived |-> res_o.velocity == '0)
    else $error("arrived result with nonzero velocity");

  // the root finishes only while the sequencer waits for it
  a_root_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sq_rsp.done) |-> state_q == S_SQWT)
    else $error("square root finished outside its wait state");

  // velocity stays inside the symmetric range so its magnitude fits
  a_vel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vel_q != {1'b1, {(W-1){1'b0}}})
    else $error("velocity reached the most negative code");
`endif

endmodule
